// File: rtl/assert_macros.svh
// assertion helpers used by the converter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define AVCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define AVCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/avcc_pkg.sv
// ----------------------------------------------------------------------------
// avcc_pkg
// Types and constants shared by the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
package avcc_pkg;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = 2;

  localparam logic [2:0]  LFB_RESET = 3'd4;
  localparam logic [23:0] MAX_RESET = 24'd263168;

  localparam logic CFG_LFB = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_INCOMPLETE = 3'd1;
  localparam logic [2:0] ST_ZERO       = 3'd2;
  localparam logic [2:0] ST_OVERRUN    = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd4;

  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_LAST = 8'h01;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_UNIT = 2'd1
  } phase_t;

  typedef enum logic [1:0] {
    CMD_DATA     = 2'd0,
    CMD_DATA_OVR = 2'd1,
    CMD_START    = 2'd2,
    CMD_STATUS   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       fe;
    logic [2:0] status;
  } cmd_t;

endpackage

// File: rtl/avcc_front.sv
// ----------------------------------------------------------------------------
// avcc_front
// Parses length fields and unit bytes, checks errors, issues commands.
// ----------------------------------------------------------------------------
module avcc_front import avcc_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_take,
  input  logic [7:0]  in_data_byte,
  input  logic        in_sample_end,
  input  logic [2:0]  lfb,
  input  logic [23:0] max_out,
  output logic        cmd_push,
  output cmd_t        cmd
);

  phase_t                phase_r, phase_nxt;
  logic [2:0]            seen_r, seen_nxt;
  logic [31:0]           ul_r, ul_nxt;
  logic [31:0]           bl_r, bl_nxt;
  logic [COUNT_BITS-1:0] wc_r, wc_nxt;
  logic                  drop_r, drop_nxt;

  logic [2:0]  lsize;
  logic [31:0] ul_shift;
  logic [2:0]  seen_inc;
  logic        len_done;
  logic        unit_last;
  logic        too_large;

  always_comb begin
    if (lfb == 3'd0) begin
      lsize = 3'd1;
    end else if (lfb > 3'd4) begin
      lsize = 3'd4;
    end else begin
      lsize = lfb;
    end
  end

  assign ul_shift  = {ul_r[23:0], in_data_byte};
  assign seen_inc  = (seen_r < 3'd7) ? seen_r + 3'd1 : seen_r;
  assign len_done  = (seen_inc >= lsize);
  assign unit_last = (bl_r == 32'd1);
  assign too_large = (34'(wc_r) + 34'd4 + 34'(ul_shift)) > 34'(max_out);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    seen_nxt  = seen_r;
    ul_nxt    = ul_r;
    bl_nxt    = bl_r;
    wc_nxt    = wc_r;
    drop_nxt  = drop_r;
    if (in_take) begin
      if (drop_r) begin
        if (in_sample_end) begin
          drop_nxt = 1'b0;
          phase_nxt = PH_LEN;
          seen_nxt = '0;
          ul_nxt = '0;
          bl_nxt = '0;
          wc_nxt = '0;
        end
      end else begin
        unique case (phase_r)
          PH_UNIT: begin
            wc_nxt = wc_r + COUNT_BITS'(1);
            bl_nxt = bl_r - 32'd1;
            if (unit_last) begin
              phase_nxt = PH_LEN;
              seen_nxt = '0;
              ul_nxt = '0;
            end
            if (in_sample_end) begin
              phase_nxt = PH_LEN;
              seen_nxt = '0;
              ul_nxt = '0;
              bl_nxt = '0;
              wc_nxt = '0;
            end
          end
          default: begin
            ul_nxt = ul_shift;
            seen_nxt = seen_inc;
            if (in_sample_end) begin
              seen_nxt = '0;
              ul_nxt = '0;
              bl_nxt = '0;
              wc_nxt = '0;
            end else if (len_done) begin
              if (ul_shift == 32'd0 || too_large) begin
                drop_nxt = 1'b1;
              end else begin
                wc_nxt = wc_r + COUNT_BITS'(4);
                bl_nxt = ul_shift;
                seen_nxt = '0;
                phase_nxt = PH_UNIT;
              end
            end
          end
        endcase
      end
    end
  end

  // command to the back end
  always_comb begin
    cmd_push   = 1'b0;
    cmd.kind   = CMD_STATUS;
    cmd.data   = in_data_byte;
    cmd.fe     = 1'b1;
    cmd.status = ST_OK;
    if (in_take && !drop_r) begin
      unique case (phase_r)
        PH_UNIT: begin
          cmd_push = 1'b1;
          if (unit_last) begin
            cmd.kind = CMD_DATA;
            cmd.fe   = in_sample_end;
          end else if (in_sample_end) begin
            cmd.kind = CMD_DATA_OVR;
          end else begin
            cmd.kind = CMD_DATA;
            cmd.fe   = 1'b0;
          end
        end
        default: begin
          if (!len_done) begin
            cmd_push   = in_sample_end;
            cmd.status = ST_INCOMPLETE;
          end else begin
            cmd_push = 1'b1;
            priority if (ul_shift == 32'd0) begin
              cmd.status = ST_ZERO;
            end else if (in_sample_end) begin
              cmd.status = ST_OVERRUN;
            end else if (too_large) begin
              cmd.status = ST_TOO_LARGE;
            end else begin
              cmd.kind = CMD_START;
              cmd.fe   = 1'b0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      seen_r  <= '0;
      ul_r    <= '0;
      bl_r    <= '0;
      wc_r    <= '0;
      drop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
      ul_r    <= ul_nxt;
      bl_r    <= bl_nxt;
      wc_r    <= wc_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

// File: rtl/avcc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// avcc_cmd_fifo
// Short command queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module avcc_cmd_fifo import avcc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic valid,
  output logic full
);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_r, rd_r;
  logic [CMD_PTR_W:0]   cnt_r, cnt_nxt;

  assign dout  = mem_r[rd_r];
  assign valid = (cnt_r != '0);
  assign full  = (cnt_r == (CMD_PTR_W+1)'(CMD_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/avcc_back.sv
// ----------------------------------------------------------------------------
// avcc_back
// Expands commands into output bytes and holds the result register.
// ----------------------------------------------------------------------------
module avcc_back import avcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_frame_end,
  output logic [2:0] out_status
);

  logic [1:0] step_r, step_nxt;
  logic       ov_r;
  logic [7:0] byte_r;
  logic       fe_r;
  logic [2:0] st_r;

  logic       advance;
  logic       last_step;
  logic [7:0] byte_nxt;
  logic       fe_nxt;
  logic [2:0] st_nxt;

  assign advance = cmd_valid && (!ov_r || pop);
  assign cmd_pop = advance && last_step;

  always_comb begin
    last_step = 1'b1;
    byte_nxt  = SC_ZERO;
    fe_nxt    = 1'b1;
    st_nxt    = ST_OK;
    unique case (cmd.kind)
      CMD_DATA: begin
        byte_nxt = cmd.data;
        fe_nxt   = cmd.fe;
      end
      CMD_DATA_OVR: begin
        last_step = (step_r == 2'd1);
        if (step_r == 2'd0) begin
          byte_nxt = cmd.data;
          fe_nxt   = 1'b0;
        end else begin
          st_nxt = ST_OVERRUN;
        end
      end
      CMD_START: begin
        last_step = (step_r == 2'd3);
        fe_nxt    = 1'b0;
        byte_nxt  = last_step ? SC_LAST : SC_ZERO;
      end
      CMD_STATUS: begin
        st_nxt = cmd.status;
      end
      default: ;
    endcase
  end

  assign step_nxt = last_step ? 2'd0 : step_r + 2'd1;

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r <= byte_nxt;
      fe_r   <= fe_nxt;
      st_r   <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (advance) begin
        step_r <= step_nxt;
        ov_r   <= 1'b1;
      end else if (pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign empty         = !ov_r;
  assign out_byte      = byte_r;
  assign out_frame_end = fe_r;
  assign out_status    = st_r;

endmodule

// File: rtl/avcc_to_annexb_converter.sv
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter
// Converts length-prefixed video samples to start-code-prefixed streams.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while full is low. A start code is four
// output bytes, which the output sequencer produces while the front keeps
// parsing until its four-entry command queue fills. A result passes through
// the command queue and then the output register before it reaches the
// output ports. Sustained rate is set by the output register: one result
// per cycle while pop is high and commands are waiting.
// No clearing pass after reset.
`include "assert_macros.svh"

module avcc_to_annexb_converter import avcc_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_sample_end,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_frame_end,
  output logic [2:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata
);

  logic [2:0]  lfb_r;
  logic [23:0] max_r;

  logic in_take;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_valid;
  logic cmd_pop;
  logic cmd_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfb_r <= LFB_RESET;
      max_r <= MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LFB: lfb_r <= cfg_wdata[2:0];
        CFG_MAX: max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign full    = cmd_full;
  assign in_take = push && !cmd_full;

  avcc_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_take      (in_take),
    .in_data_byte (in_data_byte),
    .in_sample_end(in_sample_end),
    .lfb          (lfb_r),
    .max_out      (max_r),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  avcc_cmd_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmd_push),
    .din  (cmd_in),
    .pop  (cmd_pop),
    .dout (cmd_head),
    .valid(cmd_valid),
    .full (cmd_full)
  );

  avcc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd_head),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .out_frame_end(out_frame_end),
    .out_status   (out_status)
  );

  `AVCC_ASSERT_ALWAYS(a_empty_after_reset, $past(!rst_n) |-> empty, "result after reset")
  `AVCC_ASSERT(a_no_push_full, cmd_push |-> !cmd_full, "command pushed into full queue")
  `AVCC_ASSERT(a_no_pop_empty, cmd_pop |-> cmd_valid, "command popped from empty queue")
  `AVCC_ASSERT(a_status_ends, (!empty && out_status != ST_OK) |-> out_frame_end, "error without frame end")

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefix to start-code converter. A
// directed table covers the error codes and the register extremes, then
// random samples, mostly well formed, run under a range of register
// settings. The bench keeps its own model of the converter and checks every
// popped result against the expected Annex-B stream, field by field.
// ----------------------------------------------------------------------------
module tb_top import avcc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_BITS  = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_BYTES = 32;
  localparam int MAX_PRINTS  = 30;

  typedef struct packed {
    logic [7:0] data;
    logic       fe;
    logic [2:0] status;
  } annexb_res_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } sample_byte_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    logic        chk;
    annexb_res_t want;
    logic        idx;
    logic [23:0] value;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_data_byte;
  logic        in_sample_end;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        out_frame_end;
  logic [2:0]  out_status;
  logic        cfg_we;
  logic        cfg_index;
  logic [23:0] cfg_wdata;

  avcc_to_annexb_converter #(.COUNT_BITS(COUNT_BITS)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_data_byte (in_data_byte),
    .in_sample_end(in_sample_end),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .out_frame_end(out_frame_end),
    .out_status   (out_status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // converter model state and registers
  logic [2:0]            lfb_reg;
  logic [23:0]           max_reg;
  phase_t                st_phase;
  logic [2:0]            len_seen;
  logic [31:0]           unit_len;
  logic [31:0]           remain;
  logic [COUNT_BITS-1:0] out_count;
  logic                  drop;

  annexb_res_t  annexb_q[$];
  annexb_res_t  last_made;
  int           made_now;
  sample_byte_t sample_q[$];
  stim_row_t    plan[$];

  logic        row_chk;
  annexb_res_t row_want;
  int          errors = 0;
  int          cycles = 0;
  int          bytes_sent = 0;
  int          samples_sent = 0;
  int          results_checked = 0;
  int          burst_left = 0;
  logic        no_gaps = 1'b1;
  int          rx_mode = 0;
  int          stall_left = 0;

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void restart_sample();
    st_phase  = PH_LEN;
    len_seen  = '0;
    unit_len  = '0;
    remain    = '0;
    out_count = '0;
    drop      = 1'b0;
  endfunction

  function automatic void put_result(input logic [7:0] b, input logic fe,
                                     input logic [2:0] st);
    last_made = '{data: b, fe: fe, status: st};
    annexb_q = {annexb_q, last_made};
    made_now++;
  endfunction

  function automatic void flag_error(input logic [2:0] code, input logic ends);
    put_result(8'h00, 1'b1, code);
    if (ends) restart_sample();
    else drop = 1'b1;
  endfunction

  // expected results for one accepted input byte
  function automatic void convert_byte(input logic [7:0] b, input logic last);
    logic [2:0] lsize;
    if (drop) begin
      if (last) restart_sample();
      return;
    end
    if (st_phase == PH_UNIT) begin
      remain    = remain - 1;
      out_count = out_count + 1'b1;
      if (remain == 0) begin
        put_result(b, last, ST_OK);
        if (last) restart_sample();
        else begin
          st_phase = PH_LEN;
          len_seen = '0;
          unit_len = '0;
        end
      end else begin
        put_result(b, 1'b0, ST_OK);
        if (last) flag_error(ST_OVERRUN, 1'b1);
      end
      return;
    end
    lsize = (lfb_reg == 3'd0) ? 3'd1 : (lfb_reg > 3'd4) ? 3'd4 : lfb_reg;
    unit_len = {unit_len[23:0], b};
    if (len_seen < 3'd7) len_seen++;
    if (len_seen < lsize) begin
      if (last) flag_error(ST_INCOMPLETE, 1'b1);
      return;
    end
    if (unit_len == 0) flag_error(ST_ZERO, last);
    else if (last) flag_error(ST_OVERRUN, 1'b1);
    else if (64'(out_count) + 64'd4 + 64'(unit_len) > 64'(max_reg))
      flag_error(ST_TOO_LARGE, 1'b0);
    else begin
      put_result(SC_ZERO, 1'b0, ST_OK);
      put_result(SC_ZERO, 1'b0, ST_OK);
      put_result(SC_ZERO, 1'b0, ST_OK);
      put_result(SC_LAST, 1'b0, ST_OK);
      out_count = out_count + COUNT_BITS'(4);
      remain    = unit_len;
      len_seen  = '0;
      st_phase  = PH_UNIT;
    end
  endfunction

  always @(posedge clk) begin : monitor
    annexb_res_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               annexb_q.size());
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst_n) begin
      lfb_reg = LFB_RESET;
      max_reg = MAX_RESET;
      restart_sample();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LFB) lfb_reg = cfg_wdata[2:0];
        else max_reg = cfg_wdata;
      end
      if (push && !full) begin
        made_now = 0;
        convert_byte(in_data_byte, in_sample_end);
        if (row_chk) begin
          if (made_now == 0)
            report_mismatch($sformatf("byte %02h gave no result", in_data_byte));
          else if (last_made != row_want)
            report_mismatch($sformatf("byte %02h: model gave %03h, table says %03h",
                                      in_data_byte, last_made, row_want));
        end
      end
      if (pop && !empty) begin
        got = '{data: out_byte, fe: out_frame_end, status: out_status};
        if (annexb_q.size() == 0)
          report_mismatch($sformatf("unexpected result %02h fe %0b status %0d",
                                    out_byte, out_frame_end, out_status));
        else begin
          want = annexb_q.pop_front();
          results_checked++;
          if (got.data != want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", got.data, want.data));
          if (got.fe != want.fe)
            report_mismatch($sformatf("out_frame_end %0b, expected %0b", got.fe, want.fe));
          if (got.status != want.status)
            report_mismatch($sformatf("out_status %0d, expected %0d",
                                      got.status, want.status));
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    case (rx_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
        end
      end
    endcase
  end

  // entered at a falling edge, leaves at a falling edge with push still high
  task automatic send_byte(input logic [7:0] b, input logic last, input logic chk,
                           input annexb_res_t want);
    push          = 1'b1;
    in_data_byte  = b;
    in_sample_end = last;
    row_chk       = chk;
    row_want      = want;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    if (last) samples_sent++;
  endtask

  task automatic pause_sender(input int n);
    push = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // waits until every request has drained before a register write
  task automatic write_reg(input logic idx, input logic [23:0] value);
    push = 1'b0;
    while (annexb_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic make_sample(input int lsize);
    int kind, units, ulen, zero_at, cut;
    sample_byte_t sb;
    kind = $urandom_range(0, 9);
    sample_q.delete();
    if (kind == 9) begin
      repeat ($urandom_range(1, 10)) begin
        sb = '{data: 8'($urandom_range(0, 255)), last: 1'b0};
        sample_q = {sample_q, sb};
      end
    end else begin
      units   = $urandom_range(1, 3);
      zero_at = (kind == 8) ? $urandom_range(0, units - 1) : -1;
      for (int u = 0; u < units; u++) begin
        if (u == zero_at) ulen = 0;
        else if ($urandom_range(0, 7) == 0) ulen = $urandom_range(9, 40);
        else ulen = $urandom_range(1, 8);
        for (int k = lsize - 1; k >= 0; k--) begin
          sb = '{data: 8'(ulen >> (8 * k)), last: 1'b0};
          sample_q = {sample_q, sb};
        end
        repeat (ulen) begin
          sb = '{data: 8'($urandom_range(0, 255)), last: 1'b0};
          sample_q = {sample_q, sb};
        end
      end
      // truncated sample
      if (kind == 7) begin
        cut = $urandom_range(1, sample_q.size());
        while (sample_q.size() > cut) void'(sample_q.pop_back());
      end
    end
    sb = sample_q.pop_back();
    sb.last = 1'b1;
    sample_q = {sample_q, sb};
  endtask

  function automatic stim_row_t byte_row(input logic [7:0] b, input logic last);
    return '{kind: ROW_BYTE, data: b, last: last, chk: 1'b0, want: '0, idx: 1'b0,
             value: '0};
  endfunction

  function automatic stim_row_t chk_row(input logic [7:0] b, input logic last,
                                        input logic [7:0] wb, input logic wfe,
                                        input logic [2:0] wst);
    return '{kind: ROW_BYTE, data: b, last: last, chk: 1'b1,
             want: '{data: wb, fe: wfe, status: wst}, idx: 1'b0, value: '0};
  endfunction

  function automatic stim_row_t cfg_row(input logic idx, input logic [23:0] value);
    return '{kind: ROW_CFG, data: '0, last: 1'b0, chk: 1'b0, want: '0, idx: idx,
             value: value};
  endfunction

  initial begin : stimulus
    logic [2:0]  lfb_plan [NUM_PHASES];
    logic [23:0] max_plan [NUM_PHASES];
    int          phase_bytes, lsize;
    stim_row_t   r;
    rst_n         = 1'b0;
    push          = 1'b0;
    in_data_byte  = '0;
    in_sample_end = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_LFB;
    cfg_wdata     = '0;
    row_chk       = 1'b0;
    row_want      = '0;
    lfb_plan = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd7, 3'd6, 3'd4};
    max_plan = '{24'd263168, 24'hFFFFFF, 24'd40, 24'd25, 24'd1, 24'd100, 24'd0,
                 24'd60, 24'hFFFFFF};

    plan = {
      // reset settings: four byte lengths
      byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0),
      chk_row(8'h02, 1'b0, SC_LAST, 1'b0, ST_OK),
      byte_row(8'hAA, 1'b0),
      chk_row(8'h55, 1'b1, 8'h55, 1'b1, ST_OK),
      chk_row(8'h00, 1'b1, 8'h00, 1'b1, ST_INCOMPLETE),
      byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0),
      chk_row(8'h05, 1'b1, 8'h00, 1'b1, ST_OVERRUN),
      // one byte lengths: sample ends inside a unit, then a zero length
      cfg_row(CFG_LFB, 24'd1),
      byte_row(8'h03, 1'b0), byte_row(8'h7F, 1'b0),
      chk_row(8'h80, 1'b1, 8'h00, 1'b1, ST_OVERRUN),
      chk_row(8'h00, 1'b0, 8'h00, 1'b1, ST_ZERO),
      byte_row(8'hFF, 1'b1),
      // zero limit rejects every unit
      cfg_row(CFG_MAX, 24'd0),
      chk_row(8'h01, 1'b0, 8'h00, 1'b1, ST_TOO_LARGE),
      byte_row(8'hFF, 1'b1),
      // size zero acts as one byte
      cfg_row(CFG_MAX, 24'hFFFFFF), cfg_row(CFG_LFB, 24'd0),
      chk_row(8'h01, 1'b0, SC_LAST, 1'b0, ST_OK),
      chk_row(8'h00, 1'b1, 8'h00, 1'b1, ST_OK),
      // size seven acts as four, largest length is too large
      cfg_row(CFG_LFB, 24'd7),
      byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0),
      chk_row(8'hFF, 1'b0, 8'h00, 1'b1, ST_TOO_LARGE),
      byte_row(8'h00, 1'b1)
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == ROW_CFG) write_reg(r.idx, r.value);
      else send_byte(r.data, r.last, r.chk, r.want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_LFB, 24'(lfb_plan[p]));
      write_reg(CFG_MAX, max_plan[p]);
      rx_mode = p % 3;
      no_gaps = (p % 4 == 3);
      lsize = (lfb_plan[p] == 3'd0) ? 1 : (lfb_plan[p] > 3'd4) ? 4 : int'(lfb_plan[p]);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        make_sample(lsize);
        foreach (sample_q[j]) begin
          if (!no_gaps && burst_left == 0) begin
            pause_sender($urandom_range(1, 6));
            burst_left = $urandom_range(1, 16);
          end
          if (burst_left > 0) burst_left--;
          send_byte(sample_q[j].data, sample_q[j].last, 1'b0, '0);
        end
        phase_bytes += sample_q.size();
      end
    end

    push = 1'b0;
    while (annexb_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("%0d input bytes in %0d samples, %0d results checked", bytes_sent,
             samples_sent, results_checked);
    $display("%0d length field sizes and output limits exercised, %0d cycles",
             NUM_PHASES, cycles);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
